### rtl/rsaeps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsaeps_pkg
// Shared types and constants for the RSA exponent pair selector.
// ----------------------------------------------------------------------------
package rsaeps_pkg;

	localparam int PRIME_WIDTH_DEF = 32;
	localparam int TOT_W           = 64;
	localparam int EXP_W           = 17;
	localparam int CAND_N          = 5;
	localparam int CAND_IDX_W      = 3;
	localparam int DIV_CNT_W       = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_LOOP,
		ST_DIV,
		ST_EVAL,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [EXP_W-1:0] cand_exp(input logic [CAND_IDX_W-1:0] idx);
		logic [EXP_W-1:0] e;
		unique case (idx)
			3'd0: e = EXP_W'(3);
			3'd1: e = EXP_W'(7);
			3'd2: e = EXP_W'(11);
			3'd3: e = EXP_W'(17);
			3'd4: e = EXP_W'(65537);
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

### rtl/rsa_exponent_pair_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_exponent_pair_select
// Forms phi = (p-1)(q-1), picks the first of 3, 7, 11, 17, 65537 that lies
// below phi and is coprime to it, and returns its inverse mod phi.
// ----------------------------------------------------------------------------
// One request at a time. Each Euclid step runs the shared 64-bit bit-serial
// divider between the loop and divide control states. A request passes
// through accept, multiply and handoff, a check of each candidate, and the
// Euclid steps of each candidate that lies below phi; handoff can wait on an
// output stall. The input stalls until the result has been placed in the
// output register; a waiting result does not block the next request.
module rsa_exponent_pair_select import rsaeps_pkg::*; #(
	parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [31:0]      prime_p,
	input  logic [31:0]      prime_q,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [TOT_W-1:0] totient,
	output logic [EXP_W-1:0] public_exponent,
	output logic [TOT_W-1:0] private_exponent,
	output logic             found
);

	st_t st_q, st_d;

	logic [PRIME_WIDTH-1:0]   p_s, q_s, pm_q, qm_q;
	logic [2*PRIME_WIDTH-1:0] prod;
	logic [TOT_W-1:0]         tot_q, r0_q, r1_q, a0_q, a1_q, d_q;
	logic                     n0_q, n1_q, found_q;
	logic [EXP_W-1:0]         e_q, e_cur;
	logic [CAND_IDX_W-1:0]    idx_q;
	logic                     in_acc, div_start, load_out, cand_ok;
	logic [TOT_W-1:0]         div_rem, div_acc, a0m, inv;
	div_stat_t                div_st;
	logic                     out_vld_q;

	assign p_s    = prime_p[PRIME_WIDTH-1:0];
	assign q_s    = prime_q[PRIME_WIDTH-1:0];
	assign prod   = pm_q * qm_q;
	assign e_cur  = cand_exp(idx_q);
	assign cand_ok = ({{(TOT_W-EXP_W){1'b0}}, e_cur} < tot_q);
	assign a0m    = (a0_q >= tot_q) ? a0_q - tot_q : a0_q;
	assign inv    = (n0_q && a0m != '0) ? tot_q - a0m : a0m;
	assign in_acc = in_valid && !in_stall;

	rsaeps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (r0_q),
		.divisor  (r1_q),
		.mulend   (a1_q),
		.rem      (div_rem),
		.acc      (div_acc),
		.stat     (div_st)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (in_valid) st_d = ST_MUL;
			ST_MUL:   st_d = ST_CHECK;
			ST_CHECK: begin
				if (idx_q == CAND_IDX_W'(CAND_N)) st_d = ST_DONE;
				else if (cand_ok)                 st_d = ST_LOOP;
			end
			ST_LOOP:  st_d = (r1_q == '0) ? ST_EVAL : ST_DIV;
			ST_DIV:   if (div_st.done) st_d = ST_LOOP;
			ST_EVAL:  st_d = (r0_q == TOT_W'(1)) ? ST_DONE : ST_CHECK;
			ST_DONE:  if (!out_vld_q || !out_stall) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (st_q != ST_IDLE);
		div_start = (st_q == ST_LOOP) && (r1_q != '0);
		load_out  = (st_q == ST_DONE) && (!out_vld_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load_out)       out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					pm_q <= (p_s == '0) ? '0 : p_s - 1'b1;
					qm_q <= (q_s == '0) ? '0 : q_s - 1'b1;
				end
			end
			ST_MUL: begin
				tot_q   <= TOT_W'(prod);
				idx_q   <= '0;
				found_q <= 1'b0;
				e_q     <= '0;
				d_q     <= '0;
			end
			ST_CHECK: begin
				if (idx_q != CAND_IDX_W'(CAND_N)) begin
					if (cand_ok) begin
						r0_q <= tot_q;
						r1_q <= {{(TOT_W-EXP_W){1'b0}}, e_cur};
						a0_q <= '0;
						a1_q <= TOT_W'(1);
						n0_q <= 1'b0;
						n1_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (div_st.done) begin
					r0_q <= r1_q;
					r1_q <= div_rem;
					a0_q <= a1_q;
					a1_q <= div_acc + a0_q;
					n0_q <= n1_q;
					n1_q <= !n1_q;
				end
			end
			ST_EVAL: begin
				if (r0_q == TOT_W'(1)) begin
					found_q <= 1'b1;
					e_q     <= e_cur;
					d_q     <= inv;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					totient          <= tot_q;
					public_exponent  <= e_q;
					private_exponent <= d_q;
					found            <= found_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_vld_q;

	// the shared divider only runs while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> (st_q == ST_DIV))
		else $error("divider busy outside divide state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (public_exponent == '0 && private_exponent == '0))
		else $error("exponents nonzero without found");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (private_exponent < totient && public_exponent != '0))
		else $error("inverse out of range");

endmodule

### rtl/rsaeps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsaeps_div
// Radix-2 restoring divider, one quotient bit per cycle. Alongside it the
// quotient bits are folded into acc = quotient * mulend by shift-and-add.
// ----------------------------------------------------------------------------
module rsaeps_div import rsaeps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [TOT_W-1:0] dividend,
	input  logic [TOT_W-1:0] divisor,
	input  logic [TOT_W-1:0] mulend,
	output logic [TOT_W-1:0] rem,
	output logic [TOT_W-1:0] acc,
	output div_stat_t        stat
);

	logic [TOT_W-1:0]     rem_q, dq_q, acc_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;
	logic [TOT_W:0]       trial;
	logic                 qbit;

	assign trial = {rem_q, dq_q[TOT_W-1]};
	assign qbit  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			acc_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? TOT_W'(trial - {1'b0, divisor}) : trial[TOT_W-1:0];
			dq_q  <= {dq_q[TOT_W-2:0], qbit};
			acc_q <= {acc_q[TOT_W-2:0], 1'b0} + (qbit ? mulend : '0);
		end
	end

	assign rem       = rem_q;
	assign acc       = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
